/* rtl/adc_auto_range_gain_control_core_macros.svh */
// assertion macros used by the checker file
`ifndef ADC_AUTO_RANGE_GAIN_CONTROL_CORE_MACROS_SVH
`define ADC_AUTO_RANGE_GAIN_CONTROL_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ADCARG_ASSERT_IMPLY(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ADCARG_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/adcarg_pkg.sv */
// shared types, codes and constants of the adc auto-ranging gain control
`default_nettype none
package adcarg_pkg;

	localparam int SAMPLE_W = 12;
	localparam int AD_W     = 16;
	localparam int CALIB_W  = 13;
	localparam int TRIES_W  = 3;
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;

	localparam logic [TRIES_W-1:0] MAX_TRIES = 3'd4;

	localparam logic [PADDR_W-1:0] CFG_ADDR_CALIB = 2'd0;

	// ranging window limits on the corrected sample
	localparam logic [AD_W-1:0] TH_UNITY_HI   = 16'd3900;
	localparam logic [AD_W-1:0] TH_HALF_LO    = 16'd2877;
	localparam logic [AD_W-1:0] TH_HALF_HI    = 16'd3949;
	localparam logic [AD_W-1:0] TH_QUARTER_LO = 16'd2450;
	localparam logic [AD_W-1:0] TH_QUARTER_MD = 16'd2950;

	// code conversion: q0.16 scale for 3.3 v over 12 bits, plus gain bases
	localparam logic [AD_W-1:0]     VOLT_FACTOR  = 16'd41694;
	localparam logic [AD_W-1:0]     BASE_UNITY   = 16'd0;
	localparam logic [AD_W-1:0]     BASE_HALF    = 16'd1024;
	localparam logic [AD_W-1:0]     BASE_QUARTER = 16'd1536;
	localparam logic [SAMPLE_W-1:0] CODE_MAX     = 12'd4095;

	typedef enum logic [0:0] {
		REQ_START  = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		KIND_NORMAL  = 2'd0,
		KIND_BATTERY = 2'd1,
		KIND_DIFF    = 2'd2,
		KIND_TEMP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		GAIN_QUARTER = 2'd0,
		GAIN_HALF    = 2'd1,
		GAIN_UNITY   = 2'd2,
		GAIN_DOUBLE  = 2'd3
	} gain_t;

	typedef enum logic [1:0] {
		ACT_CONVERT = 2'd0,
		ACT_READY   = 2'd1,
		ACT_FAILED  = 2'd2,
		ACT_IGNORED = 2'd3
	} action_t;

	typedef struct packed {
		logic                req_type;
		logic [1:0]          channel_kind;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		gain_t              cur_gain;
		logic [TRIES_W-1:0] tries_left;
		logic               single_shot;
		logic               busy;
	} state_t;

	typedef struct packed {
		action_t             action;
		gain_t               gain_code;
		logic                diff_enable;
		logic [SAMPLE_W-1:0] value;
	} result_t;

endpackage
`default_nettype wire

/* rtl/adcarg_ifaces.sv */
// valid/ready channel interfaces for request and result words
`default_nettype none
interface adcarg_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [1:0]  channel_kind;
	logic [11:0] sample;

	modport source(output valid, req_type, channel_kind, sample, input ready);
	modport sink(input valid, req_type, channel_kind, sample, output ready);
endinterface

interface adcarg_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  gain_code;
	logic        diff_enable;
	logic [11:0] value;

	modport source(output valid, action, gain_code, diff_enable, value, input ready);
	modport sink(input valid, action, gain_code, diff_enable, value, output ready);
endinterface
`default_nettype wire

/* rtl/adcarg_cfg.sv */
// apb register block holding the calibration offset
`default_nettype none
module adcarg_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adcarg_pkg::PADDR_W-1:0]      paddr,
	input  logic [adcarg_pkg::PDATA_W-1:0]      pwdata,
	output logic [adcarg_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready,
	output logic signed [adcarg_pkg::CALIB_W-1:0] calib_offset
);

	logic signed [adcarg_pkg::CALIB_W-1:0] calib_q;
	logic                                  wr_calib;

	assign wr_calib = psel && penable && pwrite && (paddr == adcarg_pkg::CFG_ADDR_CALIB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= '0;
		end else if (wr_calib) begin
			calib_q <= pwdata[adcarg_pkg::CALIB_W-1:0];
		end
	end

	// read back sign extended
	always_comb begin
		if (paddr == adcarg_pkg::CFG_ADDR_CALIB) begin
			prdata = {{(adcarg_pkg::PDATA_W-adcarg_pkg::CALIB_W){calib_q[adcarg_pkg::CALIB_W-1]}},
				calib_q};
		end else begin
			prdata = '0;
		end
	end

	assign pready       = 1'b1;
	assign calib_offset = calib_q;

endmodule
`default_nettype wire

/* rtl/adcarg_conv.sv */
// scales a ranged sample to a clamped 12-bit code on the 3.3 v scale
`default_nettype none
module adcarg_conv (
	input  logic [adcarg_pkg::AD_W-1:0]     ad,
	input  adcarg_pkg::gain_t               gain,
	output logic [adcarg_pkg::SAMPLE_W-1:0] code
);

	logic [adcarg_pkg::AD_W-1:0] base;
	logic [1:0]                  shift;
	logic [adcarg_pkg::AD_W-1:0] diff;
	logic [31:0]                 prod;
	logic [33:0]                 scaled;
	logic [17:0]                 whole;

	always_comb begin
		unique case (gain)
			adcarg_pkg::GAIN_QUARTER: begin
				base  = adcarg_pkg::BASE_QUARTER;
				shift = 2'd2;
			end
			adcarg_pkg::GAIN_HALF: begin
				base  = adcarg_pkg::BASE_HALF;
				shift = 2'd1;
			end
			adcarg_pkg::GAIN_UNITY: begin
				base  = adcarg_pkg::BASE_UNITY;
				shift = 2'd0;
			end
			adcarg_pkg::GAIN_DOUBLE: begin
				base  = adcarg_pkg::BASE_UNITY;
				shift = 2'd0;
			end
		endcase
	end

	// gain multiplier of 1, 2 or 4 folds into a left shift
	assign diff   = ad - base;
	assign prod   = 32'(diff) * 32'(adcarg_pkg::VOLT_FACTOR);
	assign scaled = {2'b00, prod} << shift;
	assign whole  = scaled[33:16];
	assign code   = (whole > 18'(adcarg_pkg::CODE_MAX)) ? adcarg_pkg::CODE_MAX : whole[11:0];

endmodule
`default_nettype wire

/* rtl/adcarg_step.sv */
// next-state and result logic for one request or sample word
`default_nettype none
module adcarg_step (
	input  adcarg_pkg::item_t                     item,
	input  adcarg_pkg::state_t                    cur,
	input  logic signed [adcarg_pkg::CALIB_W-1:0] calib_offset,
	output adcarg_pkg::state_t                    nxt,
	output adcarg_pkg::result_t                   res
);

	logic [adcarg_pkg::AD_W-1:0]     ad;
	logic [adcarg_pkg::SAMPLE_W-1:0] code;
	adcarg_pkg::gain_t               next_gain;
	logic                            done;
	logic [adcarg_pkg::TRIES_W-1:0]  tries_dec;

	// offset added modulo 2^16, negative sums range as large values
	assign ad = {{(adcarg_pkg::AD_W-adcarg_pkg::SAMPLE_W){1'b0}}, item.sample}
		+ {{(adcarg_pkg::AD_W-adcarg_pkg::CALIB_W){calib_offset[adcarg_pkg::CALIB_W-1]}},
		calib_offset};

	adcarg_conv u_conv (
		.ad   (ad),
		.gain (cur.cur_gain),
		.code (code)
	);

	// window check for the current gain
	always_comb begin
		next_gain = cur.cur_gain;
		done      = 1'b0;
		unique case (cur.cur_gain)
			adcarg_pkg::GAIN_UNITY: begin
				if (ad > adcarg_pkg::TH_UNITY_HI) next_gain = adcarg_pkg::GAIN_HALF;
				else done = 1'b1;
			end
			adcarg_pkg::GAIN_HALF: begin
				if (ad < adcarg_pkg::TH_HALF_LO) next_gain = adcarg_pkg::GAIN_UNITY;
				else if (ad > adcarg_pkg::TH_HALF_HI) next_gain = adcarg_pkg::GAIN_QUARTER;
				else done = 1'b1;
			end
			adcarg_pkg::GAIN_QUARTER: begin
				if (ad < adcarg_pkg::TH_QUARTER_LO) next_gain = adcarg_pkg::GAIN_HALF;
				else if (ad < adcarg_pkg::TH_QUARTER_MD) next_gain = adcarg_pkg::GAIN_UNITY;
				else done = 1'b1;
			end
			adcarg_pkg::GAIN_DOUBLE: begin
				// not a ranging gain, fall back to unity and burn a try
				next_gain = adcarg_pkg::GAIN_UNITY;
			end
		endcase
	end

	assign tries_dec = (cur.tries_left != '0) ? cur.tries_left - 3'd1 : '0;

	always_comb begin
		nxt             = cur;
		res.action      = adcarg_pkg::ACT_IGNORED;
		res.value       = '0;
		priority if (item.req_type == adcarg_pkg::REQ_START) begin
			unique case (adcarg_pkg::kind_t'(item.channel_kind))
				adcarg_pkg::KIND_NORMAL: begin
					nxt.cur_gain    = adcarg_pkg::GAIN_UNITY;
					nxt.single_shot = 1'b0;
				end
				adcarg_pkg::KIND_BATTERY: begin
					nxt.cur_gain    = adcarg_pkg::GAIN_QUARTER;
					nxt.single_shot = 1'b0;
				end
				adcarg_pkg::KIND_DIFF: begin
					nxt.cur_gain    = adcarg_pkg::GAIN_QUARTER;
					nxt.single_shot = 1'b1;
				end
				adcarg_pkg::KIND_TEMP: begin
					nxt.cur_gain    = adcarg_pkg::GAIN_DOUBLE;
					nxt.single_shot = 1'b1;
				end
			endcase
			nxt.tries_left = adcarg_pkg::MAX_TRIES;
			nxt.busy       = 1'b1;
			res.action     = adcarg_pkg::ACT_CONVERT;
		end else if (!cur.busy) begin
			res.action = adcarg_pkg::ACT_IGNORED;
		end else if (cur.single_shot) begin
			res.action = adcarg_pkg::ACT_READY;
			res.value  = item.sample;
			nxt.busy   = 1'b0;
		end else begin
			nxt.tries_left = tries_dec;
			if (done) begin
				res.action = adcarg_pkg::ACT_READY;
				res.value  = code;
				nxt.busy   = 1'b0;
			end else if (tries_dec == '0) begin
				res.action = adcarg_pkg::ACT_FAILED;
				nxt.busy   = 1'b0;
			end else begin
				res.action   = adcarg_pkg::ACT_CONVERT;
				nxt.cur_gain = next_gain;
			end
		end
		// ignored samples report all-zero fields
		if (res.action == adcarg_pkg::ACT_IGNORED) begin
			res.gain_code   = adcarg_pkg::GAIN_QUARTER;
			res.diff_enable = 1'b0;
		end else begin
			res.gain_code   = nxt.cur_gain;
			res.diff_enable = nxt.single_shot;
		end
	end

endmodule
`default_nettype wire

/* rtl/adc_auto_range_gain_control_core.sv */
// top level of the adc auto-ranging gain control
//
// channel  dir   handshake        word contents
// din      in    valid / ready    req_type, channel_kind, sample
// dout     out   valid / ready    action, gain_code, diff_enable, value
// apb      in    psel / penable   calib_offset at byte address 0, pready tied high
//
// one word accepted per cycle while din.ready is high; the word lands in the input
// register at the accepting edge and its result is loaded into the result register
// once that register can load; the ranging state updates as the word leaves the
// input register, so the following word already sees it
// a stall on dout holds the result register and, once the input register is
// also full, drops din.ready
// arst_n clears the pipeline valids, the ranging state and the offset register
`default_nettype none
module adc_auto_range_gain_control_core (
	input  logic                           clk,
	input  logic                           arst_n,
	adcarg_in_if.sink                      din,
	adcarg_out_if.source                   dout,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [adcarg_pkg::PADDR_W-1:0] paddr,
	input  logic [adcarg_pkg::PDATA_W-1:0] pwdata,
	output logic [adcarg_pkg::PDATA_W-1:0] prdata,
	output logic                           pready
);

	logic signed [adcarg_pkg::CALIB_W-1:0] calib_offset;

	// input register stage
	logic                valid_s1;
	adcarg_pkg::item_t   item_s1;
	// result register stage
	logic                valid_s2;
	adcarg_pkg::result_t res_s2;

	// ranging state
	adcarg_pkg::state_t  state_q;
	adcarg_pkg::state_t  state_nxt;
	adcarg_pkg::result_t res_nxt;

	logic adv_s2;     // result register can load
	logic take_s1;    // word in the input register is processed this cycle
	logic in_fire;

	adcarg_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.calib_offset (calib_offset)
	);

	adcarg_step u_step (
		.item         (item_s1),
		.cur          (state_q),
		.calib_offset (calib_offset),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// flow control: the result register frees up when taken or empty
	assign adv_s2    = !valid_s2 || dout.ready;
	assign take_s1   = valid_s1 && adv_s2;
	assign din.ready = !valid_s1 || adv_s2;
	assign in_fire   = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{cur_gain: adcarg_pkg::GAIN_UNITY, tries_left: '0,
				single_shot: 1'b0, busy: 1'b0};
		end else begin
			if (in_fire) valid_s1 <= 1'b1;
			else if (take_s1) valid_s1 <= 1'b0;
			if (adv_s2) valid_s2 <= valid_s1;
			if (take_s1) state_q <= state_nxt;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.req_type     <= din.req_type;
			item_s1.channel_kind <= din.channel_kind;
			item_s1.sample       <= din.sample;
		end
		if (take_s1) res_s2 <= res_nxt;
	end

	assign dout.valid       = valid_s2;
	assign dout.action      = res_s2.action;
	assign dout.gain_code   = res_s2.gain_code;
	assign dout.diff_enable = res_s2.diff_enable;
	assign dout.value       = res_s2.value;

endmodule
`default_nettype wire

/* rtl/adcarg_checker.sv */
// port-level checker for the gain control core, bound to the top level
`default_nettype none
`include "adc_auto_range_gain_control_core_macros.svh"
module adcarg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        dout_valid,
	input logic        dout_ready,
	input logic [1:0]  dout_action,
	input logic [1:0]  dout_gain_code,
	input logic        dout_diff_enable,
	input logic [11:0] dout_value
);

	`ADCARG_ASSERT_IMPLY(a_ignored_zero, clk, arst_n,
		dout_valid && (dout_action == adcarg_pkg::ACT_IGNORED),
		(dout_gain_code == adcarg_pkg::GAIN_QUARTER) && !dout_diff_enable && (dout_value == '0),
		"ignored word carries nonzero fields")

	`ADCARG_ASSERT_IMPLY(a_value_only_ready, clk, arst_n,
		dout_valid && (dout_action != adcarg_pkg::ACT_READY),
		dout_value == '0,
		"value nonzero on a word that is not value ready")

	`ADCARG_ASSERT_IMPLY(a_no_double_ranged, clk, arst_n,
		dout_valid && !dout_diff_enable,
		dout_gain_code != adcarg_pkg::GAIN_DOUBLE,
		"double gain on a ranged read")

	`ADCARG_ASSERT_IMPLY(a_diff_never_fails, clk, arst_n,
		dout_valid && dout_diff_enable,
		(dout_action == adcarg_pkg::ACT_CONVERT) || (dout_action == adcarg_pkg::ACT_READY),
		"fixed-gain read reported failure or ignore")

	`ADCARG_ASSERT_NEXT(a_stall_holds, clk, arst_n,
		dout_valid && !dout_ready,
		dout_valid && $stable(dout_action) && $stable(dout_gain_code)
			&& $stable(dout_diff_enable) && $stable(dout_value),
		"result word changed while stalled")

endmodule

bind adc_auto_range_gain_control_core adcarg_checker u_adcarg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.dout_valid       (dout.valid),
	.dout_ready       (dout.ready),
	.dout_action      (dout.action),
	.dout_gain_code   (dout.gain_code),
	.dout_diff_enable (dout.diff_enable),
	.dout_value       (dout.value)
);
`default_nettype wire
